[sv/nmru_pkg.sv]
`default_nettype none
package nmru_pkg;

   localparam int DEF_SETS = 64;
   localparam int DEF_WAYS = 8;

   localparam logic [2:0] FN_INVALIDATE = 3'd0;
   localparam logic [2:0] FN_INSERT     = 3'd1;
   localparam logic [2:0] FN_TOUCH      = 3'd2;
   localparam logic [2:0] FN_VICTIM     = 3'd3;
   localparam logic [2:0] FN_QUERY      = 3'd4;

   typedef struct packed {
      logic [2:0] func;
      logic [5:0] set_index;
      logic [2:0] way_index;
   } req_type;

   typedef struct packed {
      logic [2:0] victim_way;
      logic       entry_valid;
   } rsp_type;

endpackage
`default_nettype wire

[sv/nmru_state_ram.sv]
`default_nettype none
module nmru_state_ram #(
   parameter int SETS  = 64,
   parameter int WAYS  = 8,
   parameter int IDX_W = 6
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [IDX_W-1:0]      wr_addr,
   input  wire logic [2*WAYS-1:0]     wr_data,
   input  wire logic                  rd_en,
   input  wire logic [IDX_W-1:0]      rd_addr,
   output logic      [2*WAYS-1:0]     rd_data
);

   logic [2*WAYS-1:0] mem [SETS];
   logic [2*WAYS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/nmru_next.sv]
`default_nettype none
module nmru_next #(
   parameter int SETS  = 64,
   parameter int WAYS  = 8,
   parameter int WAY_W = 3
) (
   input  wire nmru_pkg::req_type req,
   input  wire logic [WAYS-1:0]   valid_cur,
   input  wire logic [WAYS-1:0]   used_cur,
   output logic                   wr_en,
   output logic      [WAYS-1:0]   valid_new,
   output logic      [WAYS-1:0]   used_new,
   output nmru_pkg::rsp_type      rsp
);
   import nmru_pkg::*;

   logic                set_ok;
   logic                way_ok;
   logic [WAY_W+2:0]    way_ext;
   logic [WAY_W-1:0]    way_idx;
   logic [WAYS-1:0]     way_onehot;
   logic [WAYS-1:0]     used_touch;
   logic [WAY_W-1:0]    vic_inv;
   logic [WAY_W-1:0]    vic_unused;
   logic [WAY_W-1:0]    vic_sel;
   logic [WAY_W+2:0]    vic_ext;

   assign set_ok  = {26'd0, req.set_index} < 32'(SETS);
   assign way_ok  = {29'd0, req.way_index} < 32'(WAYS);
   assign way_ext = {{WAY_W{1'b0}}, req.way_index};
   assign way_idx = way_ext[WAY_W-1:0];

   always_comb begin
      way_onehot = '0;
      way_onehot[way_idx] = 1'b1;
      used_touch = used_cur | way_onehot;
      if (&used_touch) begin
         used_touch = (WAYS > 1) ? way_onehot : '0;
      end
   end

   always_comb begin
      vic_inv    = '0;
      vic_unused = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (!valid_cur[i]) begin
            vic_inv = WAY_W'(i);
         end
         if (!used_cur[i]) begin
            vic_unused = WAY_W'(i);
         end
      end
      vic_sel = (&valid_cur) ? vic_unused : vic_inv;
   end

   assign vic_ext = {3'd0, vic_sel};

   always_comb begin
      wr_en           = 1'b0;
      valid_new       = valid_cur;
      used_new        = used_cur;
      rsp.victim_way  = 3'd0;
      rsp.entry_valid = 1'b0;
      if (set_ok) begin
         if (req.func == FN_VICTIM) begin
            rsp.victim_way = vic_ext[2:0];
         end else if (way_ok) begin
            case (req.func)
               FN_INVALIDATE: begin
                  wr_en     = 1'b1;
                  valid_new = valid_cur & ~way_onehot;
                  used_new  = used_cur & ~way_onehot;
               end
               FN_INSERT: begin
                  wr_en     = 1'b1;
                  valid_new = valid_cur | way_onehot;
                  used_new  = used_touch;
               end
               FN_TOUCH: begin
                  wr_en    = 1'b1;
                  used_new = used_touch;
               end
               FN_QUERY: begin
                  rsp.entry_valid = valid_cur[way_idx];
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end
      end
   end

endmodule
`default_nettype wire

[sv/nmru_replacement_policy_top.sv]
`default_nettype none
// Response: an accepted request moves the block into ST_LOOK, which registers the result
// and raises rsp_valid; it stays there while the result register holds an earlier result.
// Requests: a new transaction is accepted only in ST_IDLE, not while one is in ST_LOOK,
// set by the read-modify-write of the state memory through its single, registered read port.
// Reset: after reset a clearing pass writes every set, during which req_ready stays low.
module nmru_replacement_policy_top #(
   parameter int SETS = nmru_pkg::DEF_SETS,
   parameter int WAYS = nmru_pkg::DEF_WAYS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire nmru_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output nmru_pkg::rsp_type      rsp_payload
);
   import nmru_pkg::*;

   localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_LOOK  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   req_type            req_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_fire;
   logic               out_free;
   logic [IDX_W+5:0]   req_set_ext;
   logic [IDX_W+5:0]   held_set_ext;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [2*WAYS-1:0]  ram_wdata;
   logic [2*WAYS-1:0]  ram_rdata;
   logic               upd_we;
   logic [WAYS-1:0]    valid_new;
   logic [WAYS-1:0]    used_new;
   rsp_type            upd_rsp;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_set_ext  = {{IDX_W{1'b0}}, req_payload.set_index};
   assign held_set_ext = {{IDX_W{1'b0}}, req_ff.set_index};

   nmru_state_ram #(
      .SETS  (SETS),
      .WAYS  (WAYS),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_fire),
      .rd_addr (req_set_ext[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   nmru_next #(
      .SETS  (SETS),
      .WAYS  (WAYS),
      .WAY_W (WAY_W)
   ) u_next (
      .req       (req_ff),
      .valid_cur (ram_rdata[2*WAYS-1:WAYS]),
      .used_cur  (ram_rdata[WAYS-1:0]),
      .wr_en     (upd_we),
      .valid_new (valid_new),
      .used_new  (used_new),
      .rsp       (upd_rsp)
   );

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = held_set_ext[IDX_W-1:0];
      ram_wdata = {valid_new, used_new};
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (state_ff == ST_LOOK && out_free) begin
         ram_we = upd_we;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if ({{(32-IDX_W){1'b0}}, clr_ff} == 32'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_payload;
      end
      if (state_ff == ST_LOOK && out_free) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_LOOK)
      else $error("accepted transaction did not enter the lookup state");

   a_rsp_from_look: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOK))
      else $error("response appeared without a lookup");

   a_look_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK && !out_free) |-> !ram_we ##1 state_ff == ST_LOOK)
      else $error("lookup left or wrote while the result register was full");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_we)
      else $error("state memory written while idle");
`endif

endmodule
`default_nettype wire

[test/nmru_replacement_policy_checker.sv]
`default_nettype none
module nmru_replacement_policy_checker #(
   parameter int SETS = nmru_pkg::DEF_SETS,
   parameter int WAYS = nmru_pkg::DEF_WAYS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire nmru_pkg::req_type req_payload,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire nmru_pkg::rsp_type rsp_payload,
   output int                     failures,
   output int                     pending
);
   import nmru_pkg::*;

   logic [WAYS-1:0] valid_ways [SETS];
   logic [WAYS-1:0] used_ways [SETS];
   rsp_type         expected_rsp_q [$];

   function automatic rsp_type apply_operation(input req_type op);
      rsp_type         res;
      logic [WAYS-1:0] way_bit;
      int              s;
      int              w;
      res = '0;
      way_bit = '0;
      s = op.set_index;
      w = op.way_index;
      if (s >= SETS) begin
         return res;
      end
      if (op.func == FN_VICTIM) begin
         // The lowest unused way is the fallback; the lowest invalid way wins over it.
         for (int i = WAYS - 1; i >= 0; i--) begin
            if (!used_ways[s][i]) res.victim_way = 3'(i);
         end
         for (int i = WAYS - 1; i >= 0; i--) begin
            if (!valid_ways[s][i]) res.victim_way = 3'(i);
         end
      end else if (w < WAYS) begin
         way_bit[w] = 1'b1;
         case (op.func)
            FN_INVALIDATE: begin
               valid_ways[s] &= ~way_bit;
               used_ways[s] &= ~way_bit;
            end
            FN_INSERT, FN_TOUCH: begin
               if (op.func == FN_INSERT) valid_ways[s] |= way_bit;
               used_ways[s] |= way_bit;
               if (&used_ways[s]) used_ways[s] = (WAYS > 1) ? way_bit : '0;
            end
            FN_QUERY: begin
               res.entry_valid = valid_ways[s][w];
            end
            default: begin
            end
         endcase
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SETS; i++) begin
            valid_ways[i] = '0;
            used_ways[i] = '0;
         end
         expected_rsp_q.delete();
         failures = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: result transaction with none expected: victim_way %0d entry_valid %0d",
                        $time, rsp_payload.victim_way, rsp_payload.entry_valid);
               failures++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_payload.victim_way !== want.victim_way) begin
                  $display("%0t: victim_way mismatch: expected %0d, actual %0d",
                           $time, want.victim_way, rsp_payload.victim_way);
                  failures++;
               end
               if (rsp_payload.entry_valid !== want.entry_valid) begin
                  $display("%0t: entry_valid mismatch: expected %0d, actual %0d",
                           $time, want.entry_valid, rsp_payload.entry_valid);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(apply_operation(req_payload));
         end
      end
      pending = expected_rsp_q.size();
   end
endmodule
`default_nettype wire

[test/nmru_replacement_policy_top_tb.sv]
`default_nettype none
module nmru_replacement_policy_top_tb;
   import nmru_pkg::*;

   localparam logic [2:0] FN_RESERVED_FIRST = FN_QUERY + 3'd1;
   localparam logic [2:0] FN_RESERVED_LAST  = 3'd7;
   localparam int         RANDOM_OPS        = 650;
   localparam int         IDLE_LIMIT        = 5000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   int      failures;
   int      pending;
   int      idle_cycles = 0;
   int      op_count [8];
   logic    burst;

   nmru_replacement_policy_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   nmru_replacement_policy_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .failures    (failures),
      .pending     (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("** nmru_replacement_policy_top: FAILED **");
         $finish;
      end
   end

   task automatic send_op(input logic [2:0] func, input logic [5:0] set_index,
                          input logic [2:0] way_index);
      int unsigned gap;
      gap = burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= '{func: func, set_index: set_index, way_index: way_index};
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      op_count[func]++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic send_random(input int hot_base);
      int unsigned pick;
      logic [2:0]  func;
      logic [5:0]  set_index;
      pick = $urandom_range(0, 99);
      if (pick < 10) func = FN_INVALIDATE;
      else if (pick < 40) func = FN_INSERT;
      else if (pick < 65) func = FN_TOUCH;
      else if (pick < 85) func = FN_VICTIM;
      else if (pick < 95) func = FN_QUERY;
      else func = 3'($urandom_range(FN_RESERVED_FIRST, FN_RESERVED_LAST));
      // Most operations hit a few sets so that they fill up and the used bits decide.
      if ($urandom_range(0, 3) != 0) set_index = 6'(hot_base + $urandom_range(0, 3));
      else set_index = 6'($urandom_range(0, 63));
      send_op(func, set_index, 3'($urandom_range(0, 7)));
   endtask

   initial begin : receiver
      int unsigned hold;
      int          taken;
      taken = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (taken == 200) hold = 150;
         else if ((taken / 40) % 3 == 1) hold = 0;
         else hold = $urandom_range(0, 9);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int hot_base;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      burst = 1'b0;
      hot_base = 0;
      foreach (op_count[i]) op_count[i] = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      send_op(FN_QUERY, 6'd0, 3'd0);
      send_op(FN_VICTIM, 6'd0, 3'd5);
      for (int w = 0; w < 8; w++) send_op(FN_INSERT, 6'd63, 3'(w));
      send_op(FN_VICTIM, 6'd63, 3'd0);
      send_op(FN_TOUCH, 6'd63, 3'd0);
      send_op(FN_TOUCH, 6'd63, 3'd3);
      send_op(FN_VICTIM, 6'd63, 3'd7);
      send_op(FN_INVALIDATE, 6'd63, 3'd7);
      send_op(FN_QUERY, 6'd63, 3'd7);
      send_op(FN_QUERY, 6'd63, 3'd6);
      send_op(FN_VICTIM, 6'd63, 3'd2);
      send_op(FN_RESERVED_FIRST, 6'd63, 3'd1);
      send_op(FN_RESERVED_FIRST + 3'd1, 6'd63, 3'd7);
      send_op(FN_RESERVED_LAST, 6'd0, 3'd7);
      send_op(FN_INVALIDATE, 6'd0, 3'd0);
      send_op(FN_TOUCH, 6'd0, 3'd7);
      wait_drained();

      for (int i = 0; i < RANDOM_OPS; i++) begin
         if (i % 100 == 0) hot_base = $urandom_range(0, 15) * 4;
         burst = ((i / 60) % 3 == 2);
         if (i == 400) wait_drained();
         send_random(hot_base);
      end
      wait_drained();
      repeat (8) @(negedge clock);

      $display("Ran %0d operations: %0d invalidate, %0d insert, %0d touch, %0d victim,",
               op_count.sum(), op_count[FN_INVALIDATE], op_count[FN_INSERT],
               op_count[FN_TOUCH], op_count[FN_VICTIM]);
      $display("%0d query, %0d undefined; with random gaps, a long result stall and drains.",
               op_count[FN_QUERY], op_count.sum() - op_count[FN_INVALIDATE] -
               op_count[FN_INSERT] - op_count[FN_TOUCH] - op_count[FN_VICTIM] -
               op_count[FN_QUERY]);
      if (failures == 0) begin
         $display("** nmru_replacement_policy_top: PASSED **");
      end else begin
         $display("** nmru_replacement_policy_top: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire
